// File: rtl/ffa_pkg.sv
package ffa_pkg;

    localparam int INDEX_SPACE = 1024;
    localparam int AW          = $clog2(INDEX_SPACE);
    localparam int CNT_W       = AW + 1;
    // common widths for comparing run sizes / offsets against the effective length
    localparam int LCMP_W      = (CNT_W > 11) ? CNT_W : 11;
    localparam int CMP_W       = (CNT_W > 16) ? CNT_W : 16;

    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LENGTH = 1'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFIT  = 2'd1;
    localparam logic [1:0] STAT_BADIDX = 2'd2;
    localparam logic [1:0] STAT_FREE   = 2'd3;

    localparam int MARK_ALLOC_BIT = 0;
    localparam int MARK_START_BIT = 1;
    localparam logic [1:0] MARK_NONE  = 2'b00;
    localparam logic [1:0] MARK_ALLOC = 2'b01;
    localparam logic [1:0] MARK_HEAD  = 2'b11;

    typedef struct packed {
        logic             func;
        logic             reject;
        logic [1:0]       rej_status;
        logic [CNT_W-1:0] size;
        logic [AW-1:0]    off;
        logic [CNT_W-1:0] len;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] off;
    } t_res;

endpackage

// File: rtl/ffa_engine.sv
module ffa_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ffa_pkg::t_req i_req,
    output logic          o_idle,
    output logic          o_res_valid,
    input  logic          i_res_take,
    output ffa_pkg::t_res o_res
);
    import ffa_pkg::*;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_FCHK  = 3'd4;
    localparam logic [2:0] ST_FWALK = 3'd5;
    localparam logic [2:0] ST_RES   = 3'd6;

    localparam logic [AW-1:0] LAST = AW'(INDEX_SPACE - 1);

    logic [1:0]       r_mem [INDEX_SPACE];
    logic [1:0]       r_rdata;

    logic [2:0]       r_state,  n_state;
    logic [AW-1:0]    r_ptr,    n_ptr;
    logic [AW-1:0]    r_start,  n_start;
    logic [AW-1:0]    r_end,    n_end;
    logic [AW-1:0]    r_off,    n_off;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [CNT_W-1:0] r_size,   n_size;
    logic [CNT_W-1:0] r_len,    n_len;
    logic [1:0]       r_status, n_status;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [1:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic             last_in_len;
    logic [CNT_W-1:0] cnt_inc;

    assign last_in_len = (CNT_W'(r_ptr) + CNT_W'(1)) == r_len;
    assign cnt_inc     = r_cnt + CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_start   = r_start;
        n_end     = r_end;
        n_off     = r_off;
        n_cnt     = r_cnt;
        n_size    = r_size;
        n_len     = r_len;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = MARK_NONE;
        mem_raddr = r_ptr + AW'(1);   // streaming read-ahead
        unique case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_size = i_req.size;
                    n_len  = i_req.len;
                    n_cnt  = '0;
                    if (i_req.reject) begin
                        n_status = i_req.rej_status;
                        n_state  = ST_RES;
                    end else if (i_req.func == FUNC_ALLOC) begin
                        mem_raddr = '0;
                        n_ptr     = '0;
                        n_state   = ST_SCAN;
                    end else begin
                        mem_raddr = i_req.off;
                        n_ptr     = i_req.off;
                        n_state   = ST_FCHK;
                    end
                end
            end
            ST_SCAN: begin
                // r_rdata holds the mark of r_ptr
                if (r_rdata[MARK_ALLOC_BIT]) begin
                    n_cnt = '0;
                    if (last_in_len) begin
                        n_status = STAT_NOFIT;
                        n_state  = ST_RES;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end else begin
                    n_cnt = cnt_inc;
                    if (r_cnt == '0) begin
                        n_start = r_ptr;
                    end
                    if (cnt_inc == r_size) begin
                        n_end   = r_ptr;
                        n_ptr   = (r_cnt == '0) ? r_ptr : r_start;
                        n_state = ST_FILL;
                    end else if (last_in_len) begin
                        n_status = STAT_NOFIT;
                        n_state  = ST_RES;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = (r_ptr == r_start) ? MARK_HEAD : MARK_ALLOC;
                n_ptr     = r_ptr + AW'(1);
                if (r_ptr == r_end) begin
                    n_status = STAT_OK;
                    n_off    = r_start;
                    n_state  = ST_RES;
                end
            end
            ST_FCHK: begin
                if (!r_rdata[MARK_ALLOC_BIT]) begin
                    n_status = STAT_FREE;
                    n_state  = ST_RES;
                end else if (!r_rdata[MARK_START_BIT]) begin
                    n_status = STAT_BADIDX;
                    n_state  = ST_RES;
                end else begin
                    mem_we   = 1'b1;
                    n_off    = r_ptr;
                    n_status = STAT_OK;
                    if (r_ptr == LAST) begin
                        n_state = ST_RES;
                    end else begin
                        n_ptr   = r_ptr + AW'(1);
                        n_state = ST_FWALK;
                    end
                end
            end
            ST_FWALK: begin
                // block tail: plain allocated marks up to the next start or free index
                if (r_rdata == MARK_ALLOC) begin
                    mem_we = 1'b1;
                    if (r_ptr == LAST) begin
                        n_state = ST_RES;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_end    <= n_end;
        r_off    <= n_off;
        r_cnt    <= n_cnt;
        r_size   <= n_size;
        r_len    <= n_len;
        r_status <= n_status;
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RES);
    assign o_res.status = r_status;
    assign o_res.off    = r_off;

endmodule

// File: rtl/first_fit_index_range_allocator_core.sv
// First-fit allocator of contiguous index runs over [range_base, range_base+eff_len).
// Input channel (i_in_valid / o_in_stall): i_func selects allocate (run of i_run_size
// indices) or free (block starting at i_block_index). One item is worked on at a time.
// Output channel (o_out_valid / i_out_stall): one beat per item with o_status and
// o_result_index (allocated base, freed index echo, or 0 on error).
// Config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
// The mark memory takes one read and one write a cycle. eff_len is range_length capped
// at 1024. The result beat becomes valid in the same cycle that the input opens for the
// next beat. Steps per item:
//   allocate: scan the offsets up to the end of the fitting run (all of eff_len when
//   nothing fits), then write the run's marks; a rejected request skips both.
//   free: check the mark at the index, then release the block tail; the tail walk is
//   skipped when the check answers an error, and an out-of-range index skips both.
// The result sits in an output register; a new item is accepted while it waits, and
// the engine holds its next result until that register is emptied, so a stalled
// receiver backs up into o_in_stall.
// Reset: registers return to range_base 0, range_length 1024, and a clearing pass
// writes every mark free, one entry a cycle, with o_in_stall high.
// Config writes are taken during that pass.
module first_fit_index_range_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_func,
    input  logic [10:0]                     i_run_size,
    input  logic [15:0]                     i_block_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [15:0]                     o_result_index,
    input  logic                            i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import ffa_pkg::*;

    logic [15:0]       r_range_base;
    logic [10:0]       r_range_length;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [15:0]       r_result_index;

    logic [CNT_W-1:0]  eff_len;
    logic [LCMP_W-1:0] len_x;
    logic [LCMP_W-1:0] size_x;
    logic [15:0]       diff;
    logic              in_range;
    logic              start;
    logic              eng_idle;
    logic              eng_res_valid;
    logic              res_take;
    t_req              req;
    t_res              eng_res;

    assign len_x   = LCMP_W'(r_range_length);
    assign eff_len = (len_x > LCMP_W'(INDEX_SPACE)) ? CNT_W'(INDEX_SPACE) : len_x[CNT_W-1:0];
    assign size_x  = LCMP_W'(i_run_size);

    // end of range is exclusive
    assign diff     = i_block_index - r_range_base;
    assign in_range = (i_block_index >= r_range_base) && (CMP_W'(diff) < CMP_W'(eff_len));

    always_comb begin
        req.func       = i_func;
        req.size       = size_x[CNT_W-1:0];
        req.off        = diff[AW-1:0];
        req.len        = eff_len;
        req.reject     = 1'b0;
        req.rej_status = STAT_NOFIT;
        if (i_func == FUNC_ALLOC) begin
            if ((i_run_size == '0) || (size_x > LCMP_W'(eff_len))) begin
                req.reject = 1'b1;
            end
        end else if (!in_range) begin
            req.reject     = 1'b1;
            req.rej_status = STAT_BADIDX;
        end
    end

    assign o_in_stall = !eng_idle;
    assign start      = i_in_valid && eng_idle;
    assign res_take   = eng_res_valid && (!r_out_valid || !i_out_stall);

    ffa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .i_res_take  (res_take),
        .o_res       (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_base   <= '0;
            r_range_length <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_BASE:   r_range_base   <= i_cfg_data;
                CFG_RANGE_LENGTH: r_range_length <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_status       <= eng_res.status;
            r_result_index <= (eng_res.status == STAT_OK) ?
                              (r_range_base + 16'(eng_res.off)) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_index = r_result_index;

endmodule

// File: rtl/ffa_checker.sv
module ffa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status,
    input logic [15:0]                   o_result_index
);
    import ffa_pkg::*;

    // reset starts the clearing pass, no item taken right after
    a_reset_stalls: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item at a time: an accepted beat closes the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in flight");

    a_err_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_result_index == '0))
        else $error("error beat with nonzero index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_result_index)))
        else $error("stalled output beat changed");

endmodule

bind first_fit_index_range_allocator_core ffa_checker u_ffa_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ffa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    // longest allocate: full scan plus full mark write
    localparam int unsigned DRAIN_CYCLES = 2100;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_index;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_func = FUNC_ALLOC;
    logic [10:0]          i_run_size = '0;
    logic [15:0]          i_block_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [15:0]          o_result_index;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RANGE_BASE;
    logic [15:0]          i_cfg_data = '0;

    // allocator image: marks per offset, range registers, live block offsets
    logic [1:0]  marks [INDEX_SPACE];
    logic [15:0] cfg_base = 16'd0;
    logic [10:0] cfg_length = 11'd1024;
    int unsigned live_blocks [$];

    t_answer     pending_answers [$];
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_req = 0;

    first_fit_index_range_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_run_size     (i_run_size),
        .i_block_index  (i_block_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_len();
        return (cfg_length > INDEX_SPACE) ? INDEX_SPACE : cfg_length;
    endfunction

    function automatic t_answer grant_run(input logic [10:0] size);
        int unsigned len, run_start, run_count, i, k;
        t_answer ans;
        len = eff_len();
        ans.status = STAT_NOFIT;
        ans.result_index = '0;
        if (size == 0 || size > len)
            return ans;
        run_start = 0;
        run_count = 0;
        for (i = 0; i < len; i++) begin
            if (marks[i][MARK_ALLOC_BIT]) begin
                run_count = 0;
            end else begin
                if (run_count == 0)
                    run_start = i;
                run_count++;
                if (run_count == size) begin
                    for (k = 0; k < size; k++)
                        marks[run_start + k] = MARK_ALLOC;
                    marks[run_start] = MARK_HEAD;
                    live_blocks.push_back(run_start);
                    ans.status = STAT_OK;
                    ans.result_index = 16'(cfg_base + run_start);
                    return ans;
                end
            end
        end
        return ans;
    endfunction

    function automatic t_answer release_block(input logic [15:0] idx);
        int unsigned len, off, i;
        t_answer ans;
        len = eff_len();
        ans.status = STAT_BADIDX;
        ans.result_index = '0;
        if (idx < cfg_base || (idx - cfg_base) >= len)
            return ans;
        off = idx - cfg_base;
        if (!marks[off][MARK_ALLOC_BIT]) begin
            ans.status = STAT_FREE;
            return ans;
        end
        if (!marks[off][MARK_START_BIT])
            return ans;
        marks[off] = MARK_NONE;
        // tail runs to next head or free slot, may pass the current length
        for (i = off + 1; i < INDEX_SPACE; i++) begin
            if (marks[i] != MARK_ALLOC)
                break;
            marks[i] = MARK_NONE;
        end
        for (i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == off) begin
                live_blocks.delete(i);
                break;
            end
        end
        ans.status = STAT_OK;
        ans.result_index = idx;
        return ans;
    endfunction

    task automatic send_item(input logic f, input logic [10:0] sz, input logic [15:0] idx);
        int unsigned gap;
        t_answer ans;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_run_size    <= sz;
        i_block_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        ans = (f == FUNC_ALLOC) ? grant_run(sz) : release_block(idx);
        pending_answers.push_back(ans);
    endtask

    task automatic alloc_op(input logic [10:0] sz);
        send_item(FUNC_ALLOC, sz, 16'($urandom));
    endtask

    task automatic free_op(input logic [15:0] idx);
        send_item(FUNC_FREE, 11'($urandom), idx);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_RANGE_BASE)
            cfg_base = data;
        else if (idx == CFG_RANGE_LENGTH)
            cfg_length = data[10:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits of the length write are junk and must be ignored
    task automatic set_range(input logic [15:0] base, input logic [10:0] length);
        drain();
        write_reg(CFG_RANGE_BASE, base);
        write_reg(CFG_RANGE_LENGTH, {5'($urandom), length});
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        alloc_op(11'd0);
        alloc_op(11'd1024);
        alloc_op(11'd1);
        free_op(16'd0);
        alloc_op(11'd2047);
        alloc_op(11'd4);
        alloc_op(11'd3);
        free_op(16'd1);
        free_op(16'd4);
        free_op(16'd5);
        free_op(16'd1024);
        free_op(16'hFFFF);
        alloc_op(11'd2);
        alloc_op(11'd1);
        set_range(16'd100, 11'd16);
        free_op(16'd99);
        free_op(16'd100);
        free_op(16'd116);
        // base near the top so returned indices wrap
        set_range(16'hFFFC, 11'd8);
        alloc_op(11'd3);
        alloc_op(11'd1);
        alloc_op(11'd1);
        free_op(16'd3);
        set_range(16'hFFFC, 11'd0);
        alloc_op(11'd1);
        free_op(16'hFFFC);
        // block reaching past a shortened range is still fully released
        set_range(16'd0, 11'd2047);
        alloc_op(11'd20);
        set_range(16'd0, 11'd10);
        free_op(16'd8);
        alloc_op(11'd10);
    endtask

    task automatic test_backpressure();
        int unsigned k;
        set_range(16'h0200, 11'd64);
        idle_on = 1'b0;
        hold_req = 300;
        for (k = 0; k < 16; k++) begin
            if (k % 3 == 2 && live_blocks.size() != 0)
                free_op(16'(cfg_base + live_blocks[0]));
            else
                alloc_op(11'd1);
        end
        idle_on = 1'b1;
    endtask

    task automatic random_ops(input int unsigned count);
        int unsigned k, len, pick, r, top;
        logic [10:0] sz;
        for (k = 0; k < count; k++) begin
            if (k % 25 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            len = eff_len();
            top = (len == 0) ? 1 : len;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    sz = 11'($urandom_range(1, (top < 8) ? top : 8));
                else if (r < 88)
                    sz = 11'($urandom_range(1, top));
                else if (r < 94)
                    sz = 11'd0;
                else
                    sz = 11'($urandom_range(0, 2047));
                alloc_op(sz);
            end else if (pick < 85 && live_blocks.size() != 0) begin
                free_op(16'(cfg_base + live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
            end else if (pick < 93) begin
                // just below, inside, and just past the range
                free_op(16'(cfg_base + $urandom_range(0, len + 2) - 1));
            end else begin
                free_op(16'($urandom));
            end
        end
    endtask

    task automatic test_random();
        set_range(16'd0, 11'd1024);
        random_ops(70);
        set_range(16'd64512, 11'd1024);
        random_ops(40);
        set_range(16'($urandom), 11'd32);
        random_ops(150);
        set_range(16'hFFF0, 11'd24);
        random_ops(100);
        set_range(16'($urandom_range(0, 1023)), 11'd2047);
        random_ops(40);
        set_range(16'($urandom), 11'd1);
        random_ops(40);
        set_range(16'($urandom), 11'd0);
        random_ops(20);
        set_range(16'($urandom_range(0, 1023)), 11'd8);
        random_ops(100);
    endtask

    initial begin : result_check
        t_answer     want;
        int unsigned stall_left;
        int unsigned hold_left;
        logic        accepted;
        logic        stall_next;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            accepted = i_rst_n && o_out_valid && !i_out_stall;
            if (accepted) begin
                if (pending_answers.size() == 0) begin
                    $error("result beat with nothing expected: status %0d index %0h",
                           o_status, o_result_index);
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_result_index !== want.result_index) begin
                        $error("result_index: expected %0h, actual %0h",
                               want.result_index, o_result_index);
                        errors++;
                    end
                end
                stall_left = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_out_stall <= stall_next;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : main
        int unsigned i;
        for (i = 0; i < INDEX_SPACE; i++)
            marks[i] = MARK_NONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: first_fit_index_range_allocator_core.f
rtl/ffa_pkg.sv
rtl/ffa_engine.sv
rtl/first_fit_index_range_allocator_core.sv
rtl/ffa_checker.sv
verif/tb_top.sv
